### design/tpt_pkg.sv
// ---------------------------------------------------------------------------
// Tag presence tracker package
// Shared constants, words, codes and the structs that pass between the units.
// ---------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_EXITS     = 8;
    localparam int MAX_ENTERS    = 8;
    localparam int COUNT_TYPES   = 32;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CIDX_W = (COUNT_TYPES > 1) ? $clog2(COUNT_TYPES) : 1;
    localparam int MAX_LIM = (MAX_EXITS > MAX_ENTERS) ? MAX_EXITS : MAX_ENTERS;
    localparam int NUM_W  = $clog2(MAX_LIM + 1);

    localparam logic [31:0] RESET_TIMEOUT = 32'd300000;
    localparam logic [7:0]  RESET_EE_TYPE = 8'd128;
    localparam logic [7:0]  RESET_CSTART  = 8'd1;
    localparam logic [7:0]  COUNT_SAT     = 8'hFF;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_EE_TYPE = 2'd1,
        CFG_CSTART  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_EXIT    = 2'd0,
        KIND_ENTER   = 2'd1,
        KIND_COUNT   = 2'd2,
        KIND_SUMMARY = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        OP_OBSERVE = 1'b0,
        OP_REPORT  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OBS,
        S_EXIT,
        S_ENTER,
        S_COUNT,
        S_SUM
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [15:0] major;
        logic [15:0] minor;
        logic [7:0]  rssi;
        logic [7:0]  extra;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  major_low;
        logic [15:0] tag_minor;
        logic [7:0]  tag_rssi;
        logic [7:0]  tag_extra;
        logic [7:0]  tag_type;
        logic [7:0]  type_count;
        logic        any_data;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic        obs_en;
        logic [15:0] major;
        logic [15:0] minor;
        logic [7:0]  rssi;
        logic [7:0]  extra;
        logic [31:0] now_ms;
        logic [31:0] timeout;
    } t_tag_cmd;

    typedef struct packed {
        logic        valid;
        logic        pending;
        logic        expired;
        logic        hit;
        logic [15:0] major;
        logic [15:0] minor;
        logic [7:0]  rssi;
        logic [7:0]  extra;
    } t_tag_stat;

endpackage

`default_nettype wire

### design/tpt_tag_cell.sv
// ---------------------------------------------------------------------------
// Tag table cell
// Holds one tracked tag and passes the lowest-free token to its neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module tpt_tag_cell
    import tpt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_tag_cmd  i_cmd,
    input  wire logic      i_any_hit,
    input  wire logic      i_free_before,
    output logic           o_free_before,
    input  wire logic      i_kill,
    input  wire logic      i_clr_pending,
    output t_tag_stat      o_stat
);

    logic        r_valid;
    logic        r_pending;
    logic [15:0] r_major;
    logic [15:0] r_minor;
    logic [7:0]  r_rssi;
    logic [7:0]  r_extra;
    logic [31:0] r_seen;
    logic        hit;
    logic        ins;
    logic [31:0] age;

    assign hit = r_valid && (r_major == i_cmd.major) && (r_minor == i_cmd.minor);
    assign ins = i_cmd.obs_en && !i_any_hit && !r_valid && !i_free_before;
    assign o_free_before = i_free_before || !r_valid;
    assign age = i_cmd.now_ms - r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
        end else if (ins) begin
            r_valid   <= 1'b1;
            r_pending <= 1'b1;
        end else if (i_kill) begin
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
        end else if (i_clr_pending) begin
            r_pending <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins || (i_cmd.obs_en && hit)) begin
            r_major <= i_cmd.major;
            r_minor <= i_cmd.minor;
            r_rssi  <= i_cmd.rssi;
            r_extra <= i_cmd.extra;
            r_seen  <= i_cmd.now_ms;
        end
    end

    always_comb begin
        o_stat.valid   = r_valid;
        o_stat.pending = r_pending;
        o_stat.expired = age > i_cmd.timeout;
        o_stat.hit     = hit;
        o_stat.major   = r_major;
        o_stat.minor   = r_minor;
        o_stat.rssi    = r_rssi;
        o_stat.extra   = r_extra;
    end

endmodule

`default_nettype wire

### design/tpt_count_cell.sv
// ---------------------------------------------------------------------------
// Type counter cell
// One saturating sighting counter for one countable tag type.
// ---------------------------------------------------------------------------
`default_nettype none

module tpt_count_cell
    import tpt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_bump,
    input  wire logic       i_clr,
    output logic [7:0]      o_count
);

    logic [7:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clr) begin
            r_count <= '0;
        end else if (i_bump && (r_count != COUNT_SAT)) begin
            r_count <= r_count + 8'd1;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

### design/tag_presence_tracker.sv
// ---------------------------------------------------------------------------
// Tag presence tracker
// Tracks enter/exit tags and per-type sighting counts and reports them.
// ---------------------------------------------------------------------------
// An observation is taken into the input register in S_IDLE; in S_OBS every
// table cell compares the tag at once and the lowest free cell claims an
// insert through the free token chain, or a counted type bumps its counter.
// A report walks the table cells one per cycle for exits and again for
// enters, then the counter cells one per cycle, then sends the summary; a
// stalled output holds the walk. One word is processed at a time; a finished
// result waits in the output register.
`default_nettype none

module tag_presence_tracker
    import tpt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_state              r_state, n_state;
    t_in_word            r_in;
    logic [31:0]         r_timeout;
    logic [7:0]          r_ee_type;
    logic [7:0]          r_cstart;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CIDX_W-1:0]   r_cidx, n_cidx;
    logic [NUM_W-1:0]    r_num, n_num;
    logic                r_any, n_any;
    logic                r_out_valid;
    t_out_word           r_out;

    t_tag_cmd            cmd;
    t_tag_stat           stat [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0]   free_chain;
    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic [TABLE_ENTRIES-1:0] kill_sel;
    logic [TABLE_ENTRIES-1:0] clr_sel;
    logic [COUNT_TYPES-1:0]   bump_sel;
    logic [COUNT_TYPES-1:0]   cnt_clr;
    logic [7:0]          counts [COUNT_TYPES];
    logic                any_hit;
    logic                can_emit;
    logic                emit;
    t_out_word           emit_word;
    logic [7:0]          obs_type;
    logic [7:0]          type_off;
    t_tag_stat           cur;
    logic [7:0]          cur_count;
    logic                step;

    assign free_chain[0] = 1'b0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_tag
        tpt_tag_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_any_hit     (any_hit),
            .i_free_before (free_chain[g]),
            .o_free_before (free_chain[g+1]),
            .i_kill        (kill_sel[g]),
            .i_clr_pending (clr_sel[g]),
            .o_stat        (stat[g])
        );
        assign hit_vec[g] = stat[g].hit;
    end

    for (genvar g = 0; g < COUNT_TYPES; g++) begin : g_cnt
        tpt_count_cell u_cnt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bump  (bump_sel[g]),
            .i_clr   (cnt_clr[g]),
            .o_count (counts[g])
        );
    end

    assign any_hit  = |hit_vec;
    assign obs_type = r_in.major[15:8];
    assign type_off = obs_type - r_cstart;
    assign cur       = stat[r_idx];
    assign cur_count = counts[r_cidx];
    assign can_emit  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        cmd.obs_en  = (r_state == S_OBS) && (obs_type == r_ee_type);
        cmd.major   = r_in.major;
        cmd.minor   = r_in.minor;
        cmd.rssi    = r_in.rssi;
        cmd.extra   = r_in.extra;
        cmd.now_ms  = r_in.now_ms;
        cmd.timeout = r_timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= RESET_TIMEOUT;
            r_ee_type <= RESET_EE_TYPE;
            r_cstart  <= RESET_CSTART;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_EE_TYPE: r_ee_type <= i_cfg_data[7:0];
                CFG_CSTART:  r_cstart  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cidx      <= '0;
            r_num       <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cidx  <= n_cidx;
            r_num   <= n_num;
            r_any   <= n_any;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (emit) begin
            r_out <= emit_word;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cidx    = r_cidx;
        n_num     = r_num;
        n_any     = r_any;
        emit      = 1'b0;
        emit_word = '0;
        kill_sel  = '0;
        clr_sel   = '0;
        bump_sel  = '0;
        cnt_clr   = '0;
        step      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.operation == OP_REPORT) ? S_EXIT : S_OBS;
                    n_idx   = '0;
                    n_cidx  = '0;
                    n_num   = '0;
                    n_any   = 1'b0;
                end
            end
            S_OBS: begin
                if ((obs_type != r_ee_type) && (obs_type >= r_cstart) &&
                    ({1'b0, type_off} < 9'(COUNT_TYPES))) begin
                    bump_sel[CIDX_W'(type_off)] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_EXIT: begin
                if (cur.valid && cur.expired) begin
                    if (can_emit) begin
                        emit                = 1'b1;
                        emit_word.kind      = KIND_EXIT;
                        emit_word.major_low = cur.major[7:0];
                        emit_word.tag_minor = cur.minor;
                        kill_sel[r_idx]     = 1'b1;
                        n_num               = r_num + 1'b1;
                        n_any               = 1'b1;
                        step                = 1'b1;
                    end
                end else begin
                    step = 1'b1;
                end
                if (step) begin
                    if ((r_idx == IDX_W'(TABLE_ENTRIES - 1)) ||
                        (emit && (n_num == NUM_W'(MAX_EXITS)))) begin
                        n_state = S_ENTER;
                        n_idx   = '0;
                        n_num   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_ENTER: begin
                if (cur.valid && cur.pending) begin
                    if (can_emit) begin
                        emit                = 1'b1;
                        emit_word.kind      = KIND_ENTER;
                        emit_word.major_low = cur.major[7:0];
                        emit_word.tag_minor = cur.minor;
                        emit_word.tag_rssi  = cur.rssi;
                        emit_word.tag_extra = cur.extra;
                        clr_sel[r_idx]      = 1'b1;
                        n_num               = r_num + 1'b1;
                        n_any               = 1'b1;
                        step                = 1'b1;
                    end
                end else begin
                    step = 1'b1;
                end
                if (step) begin
                    if ((r_idx == IDX_W'(TABLE_ENTRIES - 1)) ||
                        (emit && (n_num == NUM_W'(MAX_ENTERS)))) begin
                        n_state = S_COUNT;
                        n_num   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_COUNT: begin
                if (cur_count != 8'd0) begin
                    if (can_emit) begin
                        emit                 = 1'b1;
                        emit_word.kind       = KIND_COUNT;
                        emit_word.tag_type   = r_cstart + 8'(r_cidx);
                        emit_word.type_count = cur_count;
                        cnt_clr[r_cidx]      = 1'b1;
                        n_any                = 1'b1;
                        step                 = 1'b1;
                    end
                end else begin
                    step = 1'b1;
                end
                if (step) begin
                    if (r_cidx == CIDX_W'(COUNT_TYPES - 1)) begin
                        n_state = S_SUM;
                    end else begin
                        n_cidx = r_cidx + 1'b1;
                    end
                end
            end
            S_SUM: begin
                if (can_emit) begin
                    emit               = 1'b1;
                    emit_word.kind     = KIND_SUMMARY;
                    emit_word.any_data = r_any;
                    emit_word.last     = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A tag is never held in two cells, so at most one cell matches.
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(hit_vec) <= 1)
        else $error("more than one table cell matches the observed tag");

    a_exit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXIT) |-> (r_num < NUM_W'(MAX_EXITS)))
        else $error("exit count passed its limit");

    a_obs_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OBS) |=> (r_state == S_IDLE))
        else $error("observation did not finish in one cycle");

    a_last_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_word.last) |-> (r_state == S_SUM))
        else $error("final word sent outside the summary step");

endmodule

`default_nettype wire
